// ===== src/ttpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttpd_pkg
// Shared types and constants for the timed threshold presence detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ttpd_pkg;

   // field widths of the streaming and register ports
   localparam int SAMPLE_W    = 10;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;
   localparam int HOLD_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd512;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_THRESHOLD = 2'd0,
      CSR_INVERT           = 2'd1,
      CSR_HIGH_HOLD_TICKS  = 2'd2,
      CSR_LOW_HOLD_TICKS   = 2'd3
   } csr_index_type;

   // command carried in req_tuser
   typedef enum logic {
      CMD_EVALUATE    = 1'b0,
      CMD_CLEAR_FLAGS = 1'b1
   } command_type;

   // one result item
   typedef struct packed {
      logic level_high;
      logic low_present;
      logic high_present;
   } result_type;

endpackage

`default_nettype wire

// ===== src/timed_threshold_presence_detector.sv =====
// ----------------------------------------------------------------------------
// timed_threshold_presence_detector
// Threshold compare with time-qualified, sticky high/low presence flags.
//
//  port group | dir | payload
//  -----------+-----+------------------------------------------------------
//  req_*      | in  | tuser: command; tdata: sample
//  rsp_*      | out | tdata: high_present, low_present, level_high
//  csr_*      | in  | write enable, register index, write data
//
// One item per cycle sustained while rsp does not stall; an accepted item
// passes the input register (loaded at the accepting edge), then the result
// register (loaded with the counter update) before it is offered on rsp.
// Synchronous active-high reset clears counters, flags, level and registers.
// A stall on rsp holds the result register; the input register still takes
// one item and req_tready drops only while both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_threshold_presence_detector #(
   parameter int SAMPLE_BITS = 10,
   parameter int COUNT_BITS  = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // requests
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [ttpd_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [9:0] sample
   input  wire                                 req_tuser,  // [0] command
   // results
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [ttpd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [0] high_present,
                                                           // [1] low_present,
                                                           // [2] level_high
   // register writes
   input  wire                                 csr_we,
   input  wire  [ttpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [ttpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CMP_BITS  = (SAMPLE_BITS < ttpd_pkg::SAMPLE_W) ?
                              SAMPLE_BITS : ttpd_pkg::SAMPLE_W;
   localparam int HOLD_BITS = (COUNT_BITS < ttpd_pkg::HOLD_W) ?
                              COUNT_BITS : ttpd_pkg::HOLD_W;

   // configuration
   logic [CMP_BITS-1:0]  threshold_ff;
   logic                 invert_ff;
   logic [HOLD_BITS-1:0] high_hold_ff;
   logic [HOLD_BITS-1:0] low_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ttpd_pkg::THRESHOLD_RESET[CMP_BITS-1:0];
         invert_ff    <= 1'b0;
         high_hold_ff <= '0;
         low_hold_ff  <= '0;
      end else if (csr_we) begin
         unique case (ttpd_pkg::csr_index_type'(csr_index))
            ttpd_pkg::CSR_SAMPLE_THRESHOLD: threshold_ff <= csr_wdata[CMP_BITS-1:0];
            ttpd_pkg::CSR_INVERT:           invert_ff    <= csr_wdata[0];
            ttpd_pkg::CSR_HIGH_HOLD_TICKS:  high_hold_ff <= csr_wdata[HOLD_BITS-1:0];
            ttpd_pkg::CSR_LOW_HOLD_TICKS:   low_hold_ff  <= csr_wdata[HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic                  in_valid_ff;
   ttpd_pkg::command_type in_command_ff;
   logic [CMP_BITS-1:0]   in_sample_ff;

   // result register
   logic                  out_valid_ff;
   ttpd_pkg::result_type  out_result_ff;
   ttpd_pkg::result_type  core_result;

   logic advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_command_ff <= ttpd_pkg::command_type'(req_tuser);
         in_sample_ff  <= req_tdata[CMP_BITS-1:0];
      end
   end

   ttpd_core #(
      .CMP_BITS   (CMP_BITS),
      .HOLD_BITS  (HOLD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .command   (in_command_ff),
      .sample    (in_sample_ff),
      .threshold (threshold_ff),
      .invert    (invert_ff),
      .high_hold (high_hold_ff),
      .low_hold  (low_hold_ff),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ttpd_pkg::RSP_TDATA_W - 3){1'b0}},
                        out_result_ff.level_high,
                        out_result_ff.low_present,
                        out_result_ff.high_present};

endmodule

`default_nettype wire

// ===== src/ttpd_core.sv =====
// ----------------------------------------------------------------------------
// ttpd_core
// Level compare, hold counters and sticky presence flags; state advances
// once per item of either command; the result is the state after that item.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpd_core #(
   parameter int CMP_BITS   = 10,
   parameter int HOLD_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          step,
   input  ttpd_pkg::command_type        command,
   input  wire  [CMP_BITS-1:0]          sample,
   input  wire  [CMP_BITS-1:0]          threshold,
   input  wire                          invert,
   input  wire  [HOLD_BITS-1:0]         high_hold,
   input  wire  [HOLD_BITS-1:0]         low_hold,
   output ttpd_pkg::result_type         result
);

   logic                  prev_level_ff, prev_level_in;
   logic [COUNT_BITS-1:0] high_count_ff, high_count_in;
   logic [COUNT_BITS-1:0] low_count_ff,  low_count_in;
   logic                  high_flag_ff,  high_flag_in;
   logic                  low_flag_ff,   low_flag_in;

   logic [COUNT_BITS-1:0] high_hold_ext;
   logic [COUNT_BITS-1:0] low_hold_ext;
   logic                  level;

   assign high_hold_ext = COUNT_BITS'(high_hold);
   assign low_hold_ext  = COUNT_BITS'(low_hold);
   assign level         = (sample >= threshold) ^ invert;

   always_comb begin
      prev_level_in = prev_level_ff;
      high_count_in = high_count_ff;
      low_count_in  = low_count_ff;
      high_flag_in  = high_flag_ff;
      low_flag_in   = low_flag_ff;
      if (command == ttpd_pkg::CMD_CLEAR_FLAGS) begin
         high_flag_in = 1'b0;
         low_flag_in  = 1'b0;
      end else begin
         // a crossing clears both counters and both flags
         if (level != prev_level_ff) begin
            high_count_in = '0;
            low_count_in  = '0;
            high_flag_in  = 1'b0;
            low_flag_in   = 1'b0;
         end else if (level) begin
            if (high_count_ff < high_hold_ext) begin
               high_count_in = high_count_ff + COUNT_BITS'(1);
            end
         end else begin
            if (low_count_ff < low_hold_ext) begin
               low_count_in = low_count_ff + COUNT_BITS'(1);
            end
         end
         if (level) begin
            if (high_count_in >= high_hold_ext) begin
               high_flag_in = 1'b1;
            end
         end else begin
            if (low_count_in >= low_hold_ext) begin
               low_flag_in = 1'b1;
            end
         end
         prev_level_in = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         high_count_ff <= '0;
         low_count_ff  <= '0;
         high_flag_ff  <= 1'b0;
         low_flag_ff   <= 1'b0;
      end else if (step) begin
         prev_level_ff <= prev_level_in;
         high_count_ff <= high_count_in;
         low_count_ff  <= low_count_in;
         high_flag_ff  <= high_flag_in;
         low_flag_ff   <= low_flag_in;
      end
   end

   always_comb begin
      result.high_present = high_flag_in;
      result.low_present  = low_flag_in;
      result.level_high   = prev_level_in;
   end

endmodule

`default_nettype wire

// ===== bench/timed_threshold_presence_detector_tb.sv =====
// ----------------------------------------------------------------------------
// timed_threshold_presence_detector_tb
// Self-checking bench for the threshold presence detector: a queue-fed request
// driver, a result monitor with a scoreboard and a tick-level prediction of
// the level, hold counters and sticky flags. The run goes through several
// register settings with random gaps on both sides and one long result stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_threshold_presence_detector_tb;

   import ttpd_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int STALL_CYCLES = 60;

   typedef struct packed {
      command_type          cmd;
      logic [SAMPLE_W-1:0]  sample;
   } tick_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;   // [9:0] sample
   logic                    req_tuser = 1'b0; // [0] command
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;        // [0] high_present, [1] low_present,
                                              // [2] level_high
   logic                    csr_we = 1'b0;
   csr_index_type           csr_index = CSR_SAMPLE_THRESHOLD;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   timed_threshold_presence_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predicted detector state and register copy
   logic [SAMPLE_W-1:0] thr_reg = THRESHOLD_RESET;
   logic                inv_reg = 1'b0;
   logic [HOLD_W-1:0]   high_hold = '0;
   logic [HOLD_W-1:0]   low_hold = '0;
   logic                level_prev = 1'b0;
   logic [HOLD_W-1:0]   high_run = '0;
   logic [HOLD_W-1:0]   low_run = '0;
   logic                high_seen = 1'b0;
   logic                low_seen = 1'b0;

   tick_type   pending_ticks[$];
   result_type expected_flags[$];
   int         queued_total = 0;
   int         checked_total = 0;
   int         fails = 0;

   logic req_fired = 1'b0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;
   logic stall_request = 1'b0;
   logic stall_taken = 1'b0;
   int   stall_left = 0;

   function automatic result_type advance_detector(input tick_type t);
      logic       lvl;
      result_type r;
      if (t.cmd == CMD_CLEAR_FLAGS) begin
         high_seen = 1'b0;
         low_seen  = 1'b0;
      end else begin
         lvl = (t.sample >= thr_reg) ^ inv_reg;
         if (lvl != level_prev) begin
            // any crossing restarts both hold times and drops both flags
            high_run  = '0;
            low_run   = '0;
            high_seen = 1'b0;
            low_seen  = 1'b0;
         end else if (lvl && high_run < high_hold) begin
            high_run++;
         end else if (!lvl && low_run < low_hold) begin
            low_run++;
         end
         if (lvl && high_run >= high_hold)
            high_seen = 1'b1;
         if (!lvl && low_run >= low_hold)
            low_seen = 1'b1;
         level_prev = lvl;
      end
      r.high_present = high_seen;
      r.low_present  = low_seen;
      r.level_high   = level_prev;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      req_fired <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_flags.push_back(
            advance_detector(tick_type'({req_tuser, req_tdata[SAMPLE_W-1:0]})));
   end

   always @(negedge clock) begin : drive_req
      tick_type next_tick;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_ticks.size() != 0 && (req_calm || $urandom_range(99) >= 26)) begin
            next_tick = pending_ticks.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_TDATA_W'(next_tick.sample);
            req_tuser  <= next_tick.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(negedge clock) begin
      if (stall_request && !stall_taken) begin
         stall_left  = STALL_CYCLES;
         stall_taken = 1'b1;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= rsp_calm || $urandom_range(99) >= 26;
      end
   end

   always @(posedge clock) begin : check_rsp
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_total++;
         got = result_type'(rsp_tdata[2:0]);
         if (expected_flags.size() == 0) begin
            $error("result %03b with nothing expected", got);
            fails++;
         end else begin
            want = expected_flags.pop_front();
            if (got.high_present !== want.high_present) begin
               $error("high_present: expected %0b, got %0b", want.high_present,
                      got.high_present);
               fails++;
            end
            if (got.low_present !== want.low_present) begin
               $error("low_present: expected %0b, got %0b", want.low_present,
                      got.low_present);
               fails++;
            end
            if (got.level_high !== want.level_high) begin
               $error("level_high: expected %0b, got %0b", want.level_high,
                      got.level_high);
               fails++;
            end
         end
      end
   end

   task automatic push_tick(input command_type cmd, input logic [SAMPLE_W-1:0] sample);
      tick_type t;
      t.cmd    = cmd;
      t.sample = sample;
      pending_ticks.push_back(t);
      queued_total++;
   endtask

   // writes all four registers back to back while nothing is in flight
   task automatic program_detector(input logic [CSR_DATA_W-1:0] thr,
                                   input logic [CSR_DATA_W-1:0] inv,
                                   input logic [CSR_DATA_W-1:0] hh,
                                   input logic [CSR_DATA_W-1:0] lh);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SAMPLE_THRESHOLD;
      csr_wdata <= thr;
      @(negedge clock);
      csr_index <= CSR_INVERT;
      csr_wdata <= inv;
      @(negedge clock);
      csr_index <= CSR_HIGH_HOLD_TICKS;
      csr_wdata <= hh;
      @(negedge clock);
      csr_index <= CSR_LOW_HOLD_TICKS;
      csr_wdata <= lh;
      @(negedge clock);
      csr_we    <= 1'b0;
      thr_reg   = thr[SAMPLE_W-1:0];
      inv_reg   = inv[0];
      high_hold = hh;
      low_hold  = lh;
   endtask

   // sample that lands on the requested level under the current settings, where the threshold allows it
   function automatic logic [SAMPLE_W-1:0] sample_for_level(input logic lvl);
      if (lvl ^ inv_reg)
         return SAMPLE_W'($urandom_range(1023, thr_reg));
      else if (thr_reg == 0)
         return SAMPLE_W'($urandom_range(1023, 0));
      else
         return SAMPLE_W'($urandom_range(thr_reg - 1, 0));
   endfunction

   // mostly runs of one level, some clears and some noise
   task automatic add_random_ticks(input int count);
      int   left;
      int   run;
      int   roll;
      logic lvl;
      left = count;
      while (left > 0) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            push_tick(CMD_CLEAR_FLAGS, SAMPLE_W'($urandom()));
            left--;
         end else if (roll < 18) begin
            push_tick(CMD_EVALUATE, SAMPLE_W'($urandom()));
            left--;
         end else begin
            run = $urandom_range(14, 1);
            lvl = 1'($urandom_range(1));
            for (int i = 0; i < run && left > 0; i++) begin
               push_tick(CMD_EVALUATE, sample_for_level(lvl));
               left--;
            end
         end
      end
   endtask

   task automatic drain();
      while (checked_total != queued_total)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : watchdog
      for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++)
         @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset settings: threshold edge, zero hold times, clear with sample ignored
      push_tick(CMD_EVALUATE, 10'd0);
      push_tick(CMD_EVALUATE, 10'd511);
      push_tick(CMD_EVALUATE, 10'd512);
      push_tick(CMD_EVALUATE, 10'd1023);
      push_tick(CMD_EVALUATE, 10'd1023);
      push_tick(CMD_CLEAR_FLAGS, 10'd1023);
      push_tick(CMD_EVALUATE, 10'd0);
      push_tick(CMD_EVALUATE, 10'd512);
      drain();

      // wide write values, inverted compare, short hold times
      program_detector(16'hFFFF, 16'h0003, 16'd3, 16'd2);
      repeat (4) push_tick(CMD_EVALUATE, 10'd0);
      repeat (3) push_tick(CMD_EVALUATE, 10'd1023);
      push_tick(CMD_CLEAR_FLAGS, 10'd0);
      push_tick(CMD_EVALUATE, 10'd1023);
      push_tick(CMD_EVALUATE, 10'd0);
      push_tick(CMD_EVALUATE, 10'd1022);
      push_tick(CMD_EVALUATE, 10'd1023);
      drain();

      program_detector(16'($urandom()), 16'hFFFE, 16'd0, 16'd0);
      add_random_ticks(80);
      drain();

      program_detector(16'hFC00, 16'd1, 16'd5, 16'hFFFF);
      add_random_ticks(80);
      drain();

      // long result stall while requests keep coming
      program_detector(16'($urandom()), 16'($urandom_range(1)),
                       16'($urandom_range(10, 1)), 16'($urandom_range(10, 1)));
      req_calm      = 1'b1;
      stall_request = 1'b1;
      add_random_ticks(80);
      drain();
      req_calm = 1'b0;

      // no gaps on either side
      program_detector(16'h03FF, 16'd0, 16'hFFFF, 16'd1);
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      add_random_ticks(80);
      drain();
      req_calm = 1'b0;
      rsp_calm = 1'b0;

      program_detector(16'($urandom()), 16'd1,
                       16'($urandom_range(6)), 16'($urandom_range(6)));
      add_random_ticks(80);
      drain();

      if (fails == 0 && expected_flags.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
src/ttpd_pkg.sv
src/ttpd_core.sv
src/timed_threshold_presence_detector.sv
bench/timed_threshold_presence_detector_tb.sv
